// ===== rtl/hgpw_pkg.sv =====
// ----------------------------------------------------------------------------
// hgpw_pkg
// Types, constants and the 8x8 hex font for the hex glyph pixel writer.
// ----------------------------------------------------------------------------
package hgpw_pkg;

	localparam int unsigned ADDR_W   = 32;
	localparam int unsigned COLOR_W  = 32;
	localparam int unsigned POS_W    = 12;
	localparam int unsigned DIGIT_W  = 4;
	localparam int unsigned STRIDE_W = 13;
	localparam int unsigned PROD_W   = POS_W + STRIDE_W;
	localparam int unsigned LIN_W    = PROD_W + 1;
	localparam int unsigned GLYPH_W  = 64;
	localparam int unsigned PIX_CNT_W = 6;

	localparam logic [COLOR_W-1:0]  BLACK_ARGB   = 32'hff00_0000;
	localparam logic [ADDR_W-1:0]   BASE_RESET   = 32'h0020_0000;
	localparam logic [STRIDE_W-1:0] STRIDE_RESET = 13'd1920;

	localparam int unsigned CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_BASE  = 2'd0,
		CFG_LINE_STRIDE = 2'd1
	} cfg_idx_t;

	// one glyph job between front and back
	typedef struct packed {
		logic [ADDR_W-1:0]  start_addr;
		logic [GLYPH_W-1:0] glyph;
		logic [COLOR_W-1:0] colour;
	} glyph_job_t;

	// one pixel write
	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [COLOR_W-1:0] value;
		logic               last;
	} pixel_t;

	// glyph rows packed with the top row in the low byte; inside a row byte
	// bit 7 is the leftmost pixel
	function automatic logic [GLYPH_W-1:0] glyph_rom(input logic [DIGIT_W-1:0] d);
		logic [GLYPH_W-1:0] g;
		case (d)
			4'h0:    g = 64'h003C_6666_6666_663C;
			4'h1:    g = 64'h001E_0C0C_0C0C_3C1C;
			4'h2:    g = 64'h007E_7E30_180C_663C;
			4'h3:    g = 64'h003C_6606_1E06_663C;
			4'h4:    g = 64'h000C_0C7E_6C60_3018;
			4'h5:    g = 64'h003C_6606_7C60_607E;
			4'h6:    g = 64'h003C_6666_7C60_663C;
			4'h7:    g = 64'h0060_6030_180C_067E;
			4'h8:    g = 64'h003C_6666_3C66_663C;
			4'h9:    g = 64'h0038_6606_3E66_663C;
			4'hA:    g = 64'h0066_667E_6666_663C;
			4'hB:    g = 64'h0078_6666_7C66_6678;
			4'hC:    g = 64'h003C_6660_6060_663C;
			4'hD:    g = 64'h0078_6C66_6666_6C78;
			4'hE:    g = 64'h007E_6060_7860_607E;
			4'hF:    g = 64'h0060_6060_7860_607E;
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

// ===== rtl/hgpw_front.sv =====
// ----------------------------------------------------------------------------
// hgpw_front
// Takes glyph requests, forms the start address and looks up the glyph.
// ----------------------------------------------------------------------------
module hgpw_front import hgpw_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [POS_W-1:0]    pos_x,
	input  logic [POS_W-1:0]    pos_y,
	input  logic [DIGIT_W-1:0]  digit,
	input  logic [COLOR_W-1:0]  fore_colour,
	input  logic [ADDR_W-1:0]   frame_base,
	input  logic [STRIDE_W-1:0] line_stride,
	output logic                job_valid,
	input  logic                job_ready,
	output glyph_job_t          job
);

	logic                v_s1;
	logic [POS_W-1:0]    x_s1;
	logic [PROD_W-1:0]   prod_s1;
	logic [DIGIT_W-1:0]  digit_s1;
	logic [COLOR_W-1:0]  colour_s1;
	logic [LIN_W-1:0]    lin;

	assign full = v_s1 && !job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!full) begin
			v_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			x_s1      <= pos_x;
			prod_s1   <= PROD_W'(pos_y) * PROD_W'(line_stride);
			digit_s1  <= digit;
			colour_s1 <= fore_colour;
		end
	end

	// pixel index of the glyph's top-left corner
	assign lin = LIN_W'(x_s1) + LIN_W'(prod_s1);

	assign job_valid      = v_s1;
	assign job.start_addr = frame_base + {{(ADDR_W-LIN_W-2){1'b0}}, lin, 2'b00};
	assign job.glyph      = glyph_rom(digit_s1);
	assign job.colour     = colour_s1;

endmodule

// ===== rtl/hgpw_job_fifo.sv =====
// ----------------------------------------------------------------------------
// hgpw_job_fifo
// Two-entry queue of glyph jobs between the front and the back.
// ----------------------------------------------------------------------------
module hgpw_job_fifo import hgpw_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_valid,
	output logic       wr_ready,
	input  glyph_job_t wr_job,
	output logic       rd_valid,
	input  logic       rd_ready,
	output glyph_job_t rd_job
);

	glyph_job_t  slot_q [2];
	logic        wptr_q;
	logic        rptr_q;
	logic [1:0]  count_q;
	logic        wr_en;
	logic        rd_en;

	assign wr_ready = (count_q != 2'd2);
	assign rd_valid = (count_q != 2'd0);
	assign wr_en    = wr_valid && wr_ready;
	assign rd_en    = rd_valid && rd_ready;
	assign rd_job   = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (wr_en) begin
				wptr_q <= ~wptr_q;
			end
			if (rd_en) begin
				rptr_q <= ~rptr_q;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wptr_q] <= wr_job;
		end
	end

endmodule

// ===== rtl/hgpw_back.sv =====
// ----------------------------------------------------------------------------
// hgpw_back
// Walks a glyph job pixel by pixel and queues the pixel writes for output.
// ----------------------------------------------------------------------------
module hgpw_back import hgpw_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	output logic                job_ready,
	input  glyph_job_t          job,
	input  logic [STRIDE_W-1:0] line_stride,
	output logic                empty,
	input  logic                pop,
	output pixel_t              pix
);

	logic                 busy_q;
	logic [PIX_CNT_W-1:0] cnt_q;
	logic [ADDR_W-1:0]    row_addr_q;
	logic [GLYPH_W-1:0]   glyph_q;
	logic [COLOR_W-1:0]   colour_q;

	pixel_t               ofifo_q [2];
	logic                 owptr_q;
	logic                 orptr_q;
	logic [1:0]           ocount_q;

	logic                 ofull;
	logic                 emit;
	logic                 take;
	logic                 last;
	logic                 opop;
	logic [2:0]           col;
	pixel_t               cur;

	assign ofull     = (ocount_q == 2'd2);
	assign emit      = busy_q && !ofull;
	assign last      = (cnt_q == {PIX_CNT_W{1'b1}});
	assign take      = job_valid && (!busy_q || (emit && last));
	assign job_ready = !busy_q || (emit && last);

	// columns run right to left, so the row byte bit index equals cnt[2:0]
	assign col       = ~cnt_q[2:0];
	assign cur.addr  = row_addr_q + {{(ADDR_W-5){1'b0}}, col, 2'b00};
	assign cur.value = glyph_q[cnt_q] ? colour_q : BLACK_ARGB;
	assign cur.last  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (emit) begin
			cnt_q <= cnt_q + PIX_CNT_W'(1);
			if (last) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			row_addr_q <= job.start_addr;
			glyph_q    <= job.glyph;
			colour_q   <= job.colour;
		end else if (emit && (cnt_q[2:0] == 3'd7)) begin
			row_addr_q <= row_addr_q + {{(ADDR_W-STRIDE_W-2){1'b0}}, line_stride, 2'b00};
		end
	end

	// two-entry output queue parts the sequencer from the consumer
	assign empty = (ocount_q == 2'd0);
	assign opop  = pop && !empty;
	assign pix   = ofifo_q[orptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owptr_q  <= 1'b0;
			orptr_q  <= 1'b0;
			ocount_q <= 2'd0;
		end else begin
			if (emit) begin
				owptr_q <= ~owptr_q;
			end
			if (opop) begin
				orptr_q <= ~orptr_q;
			end
			if (emit && !opop) begin
				ocount_q <= ocount_q + 2'd1;
			end else if (opop && !emit) begin
				ocount_q <= ocount_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ofifo_q[owptr_q] <= cur;
		end
	end

endmodule

// ===== rtl/hex_glyph_pixel_writer.sv =====
// ----------------------------------------------------------------------------
// hex_glyph_pixel_writer
// Draws an 8x8 hex digit glyph as 64 framebuffer pixel writes per request.
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle from the back sequencer while the output queue has room;
//   a following request is taken while the current glyph is still being written
// reset: queues empty, frame base 0x00200000, line stride 1920
module hex_glyph_pixel_writer import hgpw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [POS_W-1:0]     pos_x,
	input  logic [POS_W-1:0]     pos_y,
	input  logic [DIGIT_W-1:0]   digit,
	input  logic [COLOR_W-1:0]   fore_colour,
	output logic                 empty,
	input  logic                 pop,
	output logic [ADDR_W-1:0]    pixel_address,
	output logic [COLOR_W-1:0]   pixel_value,
	output logic                 last_pixel,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data
);

	logic [ADDR_W-1:0]   frame_base_q;
	logic [STRIDE_W-1:0] line_stride_q;

	logic       fj_valid;
	logic       fj_ready;
	glyph_job_t fj_job;
	logic       bj_valid;
	logic       bj_ready;
	glyph_job_t bj_job;
	pixel_t     pix;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_base_q  <= BASE_RESET;
			line_stride_q <= STRIDE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FRAME_BASE:  frame_base_q  <= cfg_data;
				CFG_LINE_STRIDE: line_stride_q <= cfg_data[STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	hgpw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.digit       (digit),
		.fore_colour (fore_colour),
		.frame_base  (frame_base_q),
		.line_stride (line_stride_q),
		.job_valid   (fj_valid),
		.job_ready   (fj_ready),
		.job         (fj_job)
	);

	hgpw_job_fifo u_job_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fj_valid),
		.wr_ready (fj_ready),
		.wr_job   (fj_job),
		.rd_valid (bj_valid),
		.rd_ready (bj_ready),
		.rd_job   (bj_job)
	);

	hgpw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (bj_valid),
		.job_ready   (bj_ready),
		.job         (bj_job),
		.line_stride (line_stride_q),
		.empty       (empty),
		.pop         (pop),
		.pix         (pix)
	);

	assign pixel_address = pix.addr;
	assign pixel_value   = pix.value;
	assign last_pixel    = pix.last;

	// within a glyph the sequencer keeps the output queue fed every cycle
	a_no_gap_in_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !last_pixel |=> !empty)
		else $error("result queue ran dry inside a glyph");

	// the result side only drains after the last pixel of a glyph
	a_drain_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(empty) |-> $past(pop && last_pixel))
		else $error("result queue emptied without a last pixel");

	// a waiting pixel stays put until it is popped
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(pixel_address) && $stable(pixel_value)
			&& $stable(last_pixel))
		else $error("waiting pixel changed before it was popped");

endmodule
